[hw/rtl/sli_pkg.sv]
// Shared types and constants for the sorted list insert engine.
// No dependencies; imported by sli_cell and sorted_list_insert_engine.
package sli_pkg;

    localparam int SLI_DEPTH = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_PUSH    = 2'd1,
        ACT_ORDERED = 2'd2,
        ACT_READ    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_READ     = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_EMPTY    = 2'd3
    } stat_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic                     en;
        act_t                     act;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

[hw/rtl/sli_cell.sv]
// One list slot: holds an entry, decides to hold, take the new value or
// take its left neighbor's entry. Depends on sli_pkg.
module sli_cell
    import sli_pkg::*;
#(
    parameter int CW  = 5,
    parameter int IDX = 0
)
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [CW-1:0]            fill,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     found_in,
    output logic signed [DATA_W-1:0] value,
    output logic                     found_out
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     occupied;
    logic                     at_fill;
    logic                     hit;
    logic                     take_new;

    assign occupied  = fill > CW'(IDX);
    assign at_fill   = fill == CW'(IDX);
    assign hit       = occupied && ((ctl.act == ACT_PUSH) ||
                       ((ctl.act == ACT_ORDERED) && (value_reg > ctl.value)));
    assign found_out = found_in | hit;
    assign take_new  = !found_in && (hit || at_fill);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.en && found_in)
        begin
            value_next = left_value;
        end
        else if (ctl.en && take_new)
        begin
            value_next = ctl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[hw/rtl/sorted_list_insert_engine.sv]
// Top level of the sorted list insert engine: a chain of sli_cell slots,
// fill counter, read-out sequencer and output register. Depends on sli_pkg.
//
// Usage: each input beat carries an action in s_axis_tuser and a signed
// value in s_axis_tdata. Append, push and ordered insert update the chain of
// cells in the cycle the beat is accepted and load one status beat
// (inserted, or full dropped) into the output register, with tlast high. A
// read-out beat returns every stored entry from head to tail, one beat per
// cycle while m_axis_tready is high, tlast on the tail entry; an empty list
// gives a single empty beat. Throughput: one insert per cycle while the
// receiver keeps m_axis_tready high; a read out holds off the input until
// the tail entry is loaded, as the single read port walks the cells. The
// output register frees the input side as soon as the pending beat is taken.
// A receiver stall freezes the output beat and holds off new input. Reset
// empties the list and the output register; slot contents are not cleared.
module sorted_list_insert_engine
    import sli_pkg::*;
#(
    parameter int DEPTH = SLI_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [DATA_W-1:0]        s_axis_tdata,  // [31:0] value
    input  logic [1:0]               s_axis_tuser,  // [1:0] action
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [DATA_W-1:0]        m_axis_tdata,  // [31:0] data
    output logic [1:0]               m_axis_tuser,  // [1:0] status
    output logic                     m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    state_t                   state_reg;
    state_t                   state_next;
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_next;
    logic [IW-1:0]            rd_idx_reg;
    logic [IW-1:0]            rd_idx_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [DATA_W-1:0]        m_data_reg;
    logic [DATA_W-1:0]        m_data_next;
    stat_t                    m_stat_reg;
    stat_t                    m_stat_next;
    logic                     m_last_reg;
    logic                     m_last_next;

    act_t                     in_act;
    logic                     in_fire;
    logic                     out_free;
    logic                     full;
    logic                     rd_last;
    logic                     load;
    logic                     rd_step;
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic                     found      [DEPTH+1];

    assign in_act   = act_t'(s_axis_tuser);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign full     = fill_reg == CW'(DEPTH);
    assign rd_last  = (CW'(rd_idx_reg) + CW'(1)) == fill_reg;

    assign ctl.en    = in_fire && (in_act != ACT_READ) && !full;
    assign ctl.act   = in_act;
    assign ctl.value = s_axis_tdata;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sli_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .fill       (fill_reg),
            .left_value ((i == 0) ? cell_value[0] : cell_value[(i == 0) ? 0 : i - 1]),
            .found_in   (found[i]),
            .value      (cell_value[i]),
            .found_out  (found[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_act == ACT_READ) && (fill_reg != '0))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free && rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        rd_step       = 1'b0;
        m_data_next   = m_data_reg;
        m_stat_next   = m_stat_reg;
        m_last_next   = m_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = out_free;
                if (in_fire && !((in_act == ACT_READ) && (fill_reg != '0)))
                begin
                    load        = 1'b1;
                    m_last_next = 1'b1;
                    if (in_act == ACT_READ)
                    begin
                        m_data_next = '0;
                        m_stat_next = STAT_EMPTY;
                    end
                    else
                    begin
                        m_data_next = s_axis_tdata;
                        m_stat_next = full ? STAT_FULL : STAT_INSERTED;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    rd_step     = 1'b1;
                    m_data_next = cell_value[rd_idx_reg];
                    m_stat_next = STAT_READ;
                    m_last_next = rd_last;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fill_next    = ctl.en ? fill_reg + CW'(1) : fill_reg;
        rd_idx_next  = in_fire ? '0 : (rd_step ? rd_idx_reg + IW'(1) : rd_idx_reg);
        m_valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_stat_reg <= m_stat_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_stat_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
